### rtl/core/path_tlv_record_parser_unit_assert.svh
// assertion macros for the path tlv record parser
`ifndef PATH_TLV_RECORD_PARSER_UNIT_ASSERT_SVH
`define PATH_TLV_RECORD_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge out of reset
`define PTLV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ptlv assertion failed");
// condition in one cycle implies a condition in the next
`define PTLV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ptlv assertion failed");
`else
`define PTLV_ASSERT(lbl, cond)
`define PTLV_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### rtl/core/ptlv_pkg.sv
// shared types and constants of the path tlv record parser
`timescale 1ns / 1ps
`default_nettype none
package ptlv_pkg;

  localparam int unsigned RECORD_BYTES = 64;
  localparam logic [7:0] POS_LAST      = 8'(RECORD_BYTES - 1);
  localparam logic [7:0] POS_HDR_LIMIT = 8'(RECORD_BYTES - 3);

  localparam logic [15:0] CODE_IPV4    = 16'h0104;
  localparam logic [15:0] CODE_PORT    = 16'h0201;
  localparam logic [15:0] CODE_IPV6    = 16'h0510;
  localparam logic [15:0] CODE_VERSION = 16'h0701;
  localparam logic [15:0] CODE_TERM    = 16'h0901;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_IGNORE
  } ptlv_phase_e;

  typedef enum logic [1:0] {
    ST_PARSING,
    ST_VALID,
    ST_INVALID
  } ptlv_status_e;

  typedef struct packed {
    logic [7:0]   pos;
    ptlv_phase_e  phase;
    logic [15:0]  code;
    logic [7:0]   left;
    ptlv_status_e status;
    logic [31:0]  ipv4;
    logic [63:0]  ipv6_hi;
    logic [63:0]  ipv6_lo;
    logic [7:0]   version;
    logic [7:0]   port;
  } ptlv_state_t;

  localparam ptlv_state_t STATE_RESET = '{
    pos:     8'd0,
    phase:   PH_TYPE,
    code:    16'd0,
    left:    8'd0,
    status:  ST_PARSING,
    ipv4:    32'd0,
    ipv6_hi: 64'd0,
    ipv6_lo: 64'd0,
    version: 8'd0,
    port:    8'd0
  };

endpackage
`default_nettype wire

### rtl/core/ptlv_step.sv
// one-word state update of the tlv parser
`timescale 1ns / 1ps
`default_nettype none
module ptlv_step import ptlv_pkg::*; (
  input  ptlv_state_t cur_i,
  input  logic [7:0]  byte_i,
  output ptlv_state_t nxt_o
);

  logic [15:0] full_code;
  logic        code_ok;
  logic [7:0]  left_dec;

  assign full_code = {cur_i.code[15:8], byte_i};
  assign code_ok   = (full_code == CODE_IPV4) || (full_code == CODE_PORT) ||
                     (full_code == CODE_IPV6) || (full_code == CODE_VERSION) ||
                     (full_code == CODE_TERM);
  assign left_dec  = (cur_i.left != 8'd0) ? cur_i.left - 8'd1 : 8'd0;

  always_comb begin
    nxt_o     = cur_i;
    nxt_o.pos = cur_i.pos + 8'd1;
    unique case (cur_i.phase)
      PH_TYPE: begin
        if (cur_i.pos > POS_HDR_LIMIT) begin
          nxt_o.phase = PH_IGNORE;
        end else begin
          nxt_o.code  = {byte_i, 8'd0};
          nxt_o.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        nxt_o.code = full_code;
        if (!code_ok) begin
          nxt_o.status = ST_INVALID;
          nxt_o.phase  = PH_IGNORE;
        end else begin
          nxt_o.left  = byte_i;
          nxt_o.phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (cur_i.code == CODE_TERM) begin
          nxt_o.status = (byte_i == 8'd0) ? ST_VALID : ST_INVALID;
          nxt_o.phase  = PH_IGNORE;
        end else begin
          unique case (cur_i.code)
            CODE_IPV4:    nxt_o.ipv4    = {cur_i.ipv4[23:0], byte_i};
            CODE_PORT:    nxt_o.port    = byte_i;
            CODE_IPV6: begin
              nxt_o.ipv6_hi = {cur_i.ipv6_hi[55:0], cur_i.ipv6_lo[63:56]};
              nxt_o.ipv6_lo = {cur_i.ipv6_lo[55:0], byte_i};
            end
            CODE_VERSION: nxt_o.version = byte_i;
            default:      nxt_o.version = cur_i.version;
          endcase
          nxt_o.left = left_dec;
          if (left_dec == 8'd0) begin
            nxt_o.phase = PH_TYPE;
          end
        end
      end
      default: nxt_o.phase = PH_IGNORE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/path_tlv_record_parser_unit.sv
// top level of the path tlv record parser
`timescale 1ns / 1ps
`default_nettype none
// Path record parser. Takes a fixed-length path record of RECORD_BYTES words,
// one byte per word, and walks it as a chain of type-length-value entries
// (ipv4, port, ipv6, version, terminator). A word can be taken in every
// cycle: each byte needs a combinational update of the parse state, which is
// the only loop in the design. The word is held in an input register, the
// state is updated from it, and on the last byte of a record one result word
// is loaded into the result register when the held byte moves on;
// the parse state then clears itself for the next record. The result carries
// the valid flag and the last captured fields, all zero when the record is
// invalid. The input side stalls only while a result waits on a stalled
// output and the held byte cannot move on.
`include "path_tlv_record_parser_unit_assert.svh"
module path_tlv_record_parser_unit import ptlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  path_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        path_valid_o,
  output logic [7:0]  root_version_o,
  output logic [7:0]  root_port_o,
  output logic [31:0] root_ipv4_o,
  output logic [63:0] root_ipv6_high_o,
  output logic [63:0] root_ipv6_low_o
);

  // input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;

  // parse state
  ptlv_state_t state_q, state_d, state_nxt;

  // result register
  logic        res_valid_q, res_valid_d;
  logic        res_ok_q;
  logic [7:0]  res_version_q, res_port_q;
  logic [31:0] res_ipv4_q;
  logic [63:0] res_hi_q, res_lo_q;

  logic in_take;
  logic fire;
  logic last_byte;
  logic rec_ok;
  logic res_zero;

  // the held word moves on unless a result is stuck behind a stalled output
  assign fire      = in_valid_q && !(res_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take   = in_valid_i && !in_stall_o;
  assign last_byte = (state_q.pos == POS_LAST);
  assign rec_ok    = (state_nxt.status == ST_VALID);

  ptlv_step u_step (
    .cur_i  (state_q),
    .byte_i (in_byte_q),
    .nxt_o  (state_nxt)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // state clears itself after the last byte of a record
  always_comb begin
    state_d = state_q;
    if (fire) begin
      state_d = last_byte ? STATE_RESET : state_nxt;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (fire && last_byte) begin
      res_valid_d = 1'b1;
    end else if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= STATE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= path_byte_i;
    end
    if (fire && last_byte) begin
      res_ok_q      <= rec_ok;
      res_version_q <= rec_ok ? state_nxt.version : 8'd0;
      res_port_q    <= rec_ok ? state_nxt.port    : 8'd0;
      res_ipv4_q    <= rec_ok ? state_nxt.ipv4    : 32'd0;
      res_hi_q      <= rec_ok ? state_nxt.ipv6_hi : 64'd0;
      res_lo_q      <= rec_ok ? state_nxt.ipv6_lo : 64'd0;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign path_valid_o     = res_ok_q;
  assign root_version_o   = res_version_q;
  assign root_port_o      = res_port_q;
  assign root_ipv4_o      = res_ipv4_q;
  assign root_ipv6_high_o = res_hi_q;
  assign root_ipv6_low_o  = res_lo_q;

  // every captured field of the result register is zero
  assign res_zero = (res_version_q == 8'd0) && (res_port_q == 8'd0) &&
                    (res_ipv4_q == 32'd0) && (res_hi_q == 64'd0) && (res_lo_q == 64'd0);

  // position never runs past the record
  `PTLV_ASSERT(a_pos_range, state_q.pos <= POS_LAST)
  // the last byte of a record always yields a result and restarts the record
  `PTLV_ASSERT_NEXT(a_last_gives_result, fire && last_byte, res_valid_q && state_q.pos == 8'd0)
  // an invalid record reports all fields as zero
  `PTLV_ASSERT(a_invalid_zero, !(res_valid_q && !res_ok_q) || res_zero)

endmodule
`default_nettype wire
